// ===== rtl/stx_lfr_pkg.sv =====
// Package for the STX length-prefixed frame receiver.
// Holds byte widths and framing constants; no dependencies.
package stx_lfr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned REMAIN_W   = LEN_W + 1;
  localparam int unsigned SYNC_CNT_W = 2;
  localparam int unsigned LEN_CNT_W  = 2;

  localparam logic [BYTE_W-1:0]     SYNC_BYTE  = 8'h02;
  localparam logic [SYNC_CNT_W-1:0] SYNC_LAST  = 2'd3;
  localparam logic [LEN_CNT_W-1:0]  LEN_LAST   = 2'd3;
  localparam logic [REMAIN_W-1:0]   CSUM_BYTES = 33'd1;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== rtl/stx_length_frame_receiver.sv =====
// Top level of the STX length-prefixed frame receiver.
// Depends on stx_lfr_pkg for widths and framing constants.
//
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) carries one received
//   byte per item. The block hunts for four consecutive 0x02 bytes, then
//   takes a 4-byte big-endian length L, then passes L payload bytes and one
//   checksum byte to the output channel (out_valid / out_stall /
//   out_data_byte / out_is_last / out_checksum_ok). Sync and length bytes
//   give no output item. On the checksum byte out_is_last is 1 and
//   out_checksum_ok tells whether the XOR of the payload equals it.
//   Throughput: one item per cycle while no result is held by out_stall.
//   An accepted item is held in the input register, then processed into
//   the output register, from which it can be taken.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the sync hunt.
//   When out_stall holds a result, the input register still fills once;
//   in_stall then rises until the result is taken.
module stx_length_frame_receiver (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  stx_lfr_pkg::byte_t    in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output stx_lfr_pkg::byte_t    out_data_byte,
  output logic                  out_is_last,
  output logic                  out_checksum_ok
);
  import stx_lfr_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_BODY
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [SYNC_CNT_W-1:0] sync_r, sync_nxt;
  logic [LEN_CNT_W-1:0]  lcnt_r, lcnt_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [REMAIN_W-1:0]   remain_r, remain_nxt;
  byte_t                 xor_r, xor_nxt;

  logic  in_vld_r;
  byte_t in_byte_r;

  logic  out_vld_r, out_vld_nxt;
  byte_t out_byte_r;
  logic  out_last_r, out_last_nxt;
  logic  out_ok_r, out_ok_nxt;

  logic advance;
  logic fire;

  assign advance  = !(out_vld_r && out_stall);
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  always_comb begin
    phase_nxt    = phase_r;
    sync_nxt     = sync_r;
    lcnt_nxt     = lcnt_r;
    len_nxt      = len_r;
    remain_nxt   = remain_r;
    xor_nxt      = xor_r;
    out_vld_nxt  = 1'b0;
    out_last_nxt = 1'b0;
    out_ok_nxt   = 1'b0;
    case (phase_r)
      PH_LENGTH: begin
        len_nxt  = {len_r[LEN_W-BYTE_W-1:0], in_byte_r};
        lcnt_nxt = lcnt_r + 1'b1;
        if (lcnt_r == LEN_LAST) begin
          remain_nxt = {1'b0, len_nxt} + CSUM_BYTES;
          xor_nxt    = '0;
          phase_nxt  = PH_BODY;
        end
      end
      PH_BODY: begin
        out_vld_nxt = 1'b1;
        if (remain_r <= CSUM_BYTES) begin
          out_last_nxt = 1'b1;
          out_ok_nxt   = (xor_r == in_byte_r);
          phase_nxt    = PH_HUNT;
          sync_nxt     = '0;
          lcnt_nxt     = '0;
          len_nxt      = '0;
          remain_nxt   = '0;
          xor_nxt      = '0;
        end else begin
          xor_nxt    = xor_r ^ in_byte_r;
          remain_nxt = remain_r - CSUM_BYTES;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (in_byte_r == SYNC_BYTE) begin
          sync_nxt = sync_r + 1'b1;
          if (sync_r == SYNC_LAST) begin
            phase_nxt = PH_LENGTH;
            sync_nxt  = '0;
            lcnt_nxt  = '0;
            len_nxt   = '0;
          end
        end else begin
          sync_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_rx_byte;
    end
    if (fire) begin
      out_byte_r <= in_byte_r;
    end
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
      out_ok_r   <= 1'b0;
      phase_r    <= PH_HUNT;
      sync_r     <= '0;
      lcnt_r     <= '0;
      len_r      <= '0;
      remain_r   <= '0;
      xor_r      <= '0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= fire && out_vld_nxt;
      end
      if (fire) begin
        out_last_r <= out_last_nxt;
        out_ok_r   <= out_ok_nxt;
        phase_r    <= phase_nxt;
        sync_r     <= sync_nxt;
        lcnt_r     <= lcnt_nxt;
        len_r      <= len_nxt;
        remain_r   <= remain_nxt;
        xor_r      <= xor_nxt;
      end
    end
  end

  assign out_valid       = out_vld_r;
  assign out_data_byte   = out_byte_r;
  assign out_is_last     = out_last_r;
  assign out_checksum_ok = out_ok_r;

endmodule

// ===== rtl/stx_lfr_checker.sv =====
// Port-level checks for the STX length-prefixed frame receiver.
// Depends on stx_lfr_pkg; bound to stx_length_frame_receiver below.
module stx_lfr_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  stx_lfr_pkg::byte_t in_rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  stx_lfr_pkg::byte_t out_data_byte,
  input  logic               out_is_last,
  input  logic               out_checksum_ok
);
  import stx_lfr_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output item present after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");

  a_ok_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_last) |-> !out_checksum_ok)
    else $error("checksum flag on a non-final item");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_rx_byte)))
    else $error("stalled input item changed");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data_byte)
                                  && $stable(out_is_last) && $stable(out_checksum_ok)))
    else $error("stalled item dropped or changed");

endmodule

bind stx_length_frame_receiver stx_lfr_checker u_stx_lfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_rx_byte      (in_rx_byte),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_data_byte   (out_data_byte),
  .out_is_last     (out_is_last),
  .out_checksum_ok (out_checksum_ok)
);
